### hw/rtl/dews_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dews_pkg
// Shared constants, types and helpers for the diffusion edge-weight stencil.
// ----------------------------------------------------------------------------
package dews_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COND_W     = FRAC_BITS + 1;
  localparam int WGT_W      = COND_W + 1;
  localparam int PIX_W      = 8;
  localparam int ROWS_REG_W = 11;
  localparam int COLS_REG_W = 12;
  localparam int K_W        = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 21;
  localparam int DEN_W      = 22;
  localparam int REM_W      = 23;
  localparam int QDEPTH     = 4;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 96;
  localparam int NREADS     = 5;

  localparam int DEF_MAX_COLS = 2048;
  localparam int DEF_MAX_ROWS = 1024;

  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [COLS_REG_W-1:0] COLS_RESET = 12'd2048;
  localparam logic [K_W-1:0]        K_RESET    = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KSQ  = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Work for one item, decided by the front end.
  typedef struct packed {
    logic             wr;
    logic             cond_do;
    logic             outp;
    logic             has_n;
    logic             has_s;
    logic             has_w;
    logic             has_e;
    logic             int_c;
    logic             int_n;
    logic             int_s;
    logic             int_w;
    logic             int_e;
    logic             last;
    logic [1:0]       in_slot;
    logic [1:0]       out_slot;
    logic [PIX_W-1:0] pix;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Row slots of the three-row line stores count modulo three.
  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

endpackage

### hw/rtl/diffusion_edge_weight_stencil.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffusion_edge_weight_stencil
// Sobel-gradient conductance and north/south/west/east edge weights for each pixel.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields (lowest bit up)
// s_*      in   tdata: pixel[7:0]; tuser: op
// m_*      out  tdata: weight_north, weight_south, weight_west, weight_east,
//               conductance, zero fill; tlast: frame_last
// cfg_*    in   index 0 image_rows, 1 image_cols, 2 k_squared
//
// An interior pixel spends most of its back-end time in the 17-step
// conductance divider; a pixel with no conductance to work out, and a flush
// item, skip the divider.
// Reset is synchronous; the line stores need no clearing pass.
// The four-entry queue lets the input keep taking items while the back end
// works or the output register waits for a transfer.
// ----------------------------------------------------------------------------
module diffusion_edge_weight_stencil import dews_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pixel
  input  logic [0:0]            s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // wn, ws, ww, we, conductance
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int ROW_W = $clog2(MAX_ROWS + 3);
  localparam int COL_W = $clog2(MAX_COLS + 1);
  localparam int CA_W  = $clog2(MAX_COLS);
  localparam int QW    = $bits(cmd_t) + 2 * CA_W;

  logic [ROWS_REG_W-1:0] image_rows;
  logic [COLS_REG_W-1:0] image_cols;
  logic [K_W-1:0]        k_squared;
  logic [ROW_W-1:0]      rows_used;
  logic [COL_W-1:0]      cols_used;
  logic                  restart;

  qstat_t          qstat;
  logic            q_push, q_pop;
  cmd_t            f_cmd, b_cmd;
  logic [CA_W-1:0] f_in_col, f_out_col, b_in_col, b_out_col;
  logic [QW-1:0]   q_dout;

  logic [WGT_W-1:0]  wn, ws, ww, we;
  logic [COND_W-1:0] cond;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows <= ROWS_RESET;
      image_cols <= COLS_RESET;
      k_squared  <= K_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS: image_rows <= cfg_data[ROWS_REG_W-1:0];
        REG_COLS: image_cols <= cfg_data[COLS_REG_W-1:0];
        REG_KSQ:  k_squared  <= cfg_data[K_W-1:0];
        default:  ;
      endcase
    end
  end

  assign restart = cfg_we && ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS));

  always_comb begin
    if (32'(image_rows) > MAX_ROWS) begin
      rows_used = ROW_W'(MAX_ROWS);
    end else if (image_rows < ROWS_REG_W'(3)) begin
      rows_used = ROW_W'(3);
    end else begin
      rows_used = ROW_W'(image_rows);
    end
    if (32'(image_cols) > MAX_COLS) begin
      cols_used = COL_W'(MAX_COLS);
    end else if (image_cols < COLS_REG_W'(3)) begin
      cols_used = COL_W'(3);
    end else begin
      cols_used = COL_W'(image_cols);
    end
  end

  dews_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tuser[0]),
    .in_pix     (s_tdata[PIX_W-1:0]),
    .rows       (rows_used),
    .cols       (cols_used),
    .restart    (restart),
    .qstat      (qstat),
    .push       (q_push),
    .cmd        (f_cmd),
    .cmd_in_col (f_in_col),
    .cmd_out_col(f_out_col)
  );

  dews_queue #(
    .WIDTH(QW),
    .DEPTH(QDEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  ({f_cmd, f_in_col, f_out_col}),
    .pop  (q_pop),
    .dout (q_dout),
    .qstat(qstat)
  );

  assign {b_cmd, b_in_col, b_out_col} = q_dout;

  dews_back #(
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .q_cmd    (b_cmd),
    .q_in_col (b_in_col),
    .q_out_col(b_out_col),
    .pop      (q_pop),
    .k_sq     (k_squared),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_wn   (wn),
    .out_ws   (ws),
    .out_ww   (ww),
    .out_we   (we),
    .out_cond (cond),
    .out_last (m_tlast)
  );

  assign m_tdata = {(OUT_DATA_W - 4 * WGT_W - COND_W)'(0), cond, we, ww, ws, wn};

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |-> !qstat.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty)
    else $error("queue read while empty");

  a_cond_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cond <= COND_W'(1 << FRAC_BITS)) && (wn <= {cond, 1'b0} + WGT_W'(1 << FRAC_BITS)))
    else $error("conductance or weight out of range");

endmodule

### hw/rtl/dews_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dews_front
// Accepts items, tracks input and output raster positions, and queues work.
// ----------------------------------------------------------------------------
module dews_front import dews_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  localparam int ROW_W = $clog2(MAX_ROWS + 3),
  localparam int COL_W = $clog2(MAX_COLS + 1),
  localparam int CA_W  = $clog2(MAX_COLS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_op,
  input  logic [PIX_W-1:0] in_pix,
  input  logic [ROW_W-1:0] rows,
  input  logic [COL_W-1:0] cols,
  input  logic             restart,
  input  qstat_t           qstat,
  output logic             push,
  output cmd_t             cmd,
  output logic [CA_W-1:0]  cmd_in_col,
  output logic [CA_W-1:0]  cmd_out_col
);

  logic [ROW_W-1:0] in_row, out_row;
  logic [COL_W-1:0] in_col, out_col;
  logic [1:0]       in_slot, out_slot;
  logic             phase_in, phase_out, drop, accept;
  logic             rin_c, rin_n, rin_s, cin_c, cin_w, cin_e;

  assign in_ready  = !qstat.full;
  assign accept    = in_valid && in_ready;
  assign phase_in  = in_row < rows;
  // The first result is due once two rows and one pixel have gone in.
  assign phase_out = (in_row > ROW_W'(2)) || ((in_row == ROW_W'(2)) && (in_col != '0));
  assign drop      = phase_in && (in_op == OP_FLUSH);
  assign push      = accept && !drop;

  assign rin_c = (out_row >= ROW_W'(1)) && (out_row <= rows - ROW_W'(2));
  assign rin_n = (out_row >= ROW_W'(2)) && (out_row <= rows - ROW_W'(1));
  assign rin_s = out_row <= rows - ROW_W'(3);
  assign cin_c = (out_col >= COL_W'(1)) && (out_col <= cols - COL_W'(2));
  assign cin_w = (out_col >= COL_W'(2)) && (out_col <= cols - COL_W'(1));
  assign cin_e = out_col <= cols - COL_W'(3);

  always_comb begin
    cmd.wr       = phase_in;
    cmd.cond_do  = phase_in && (in_row >= ROW_W'(2)) && (in_col >= COL_W'(2));
    cmd.outp     = phase_out;
    cmd.has_n    = out_row != '0;
    cmd.has_s    = out_row < rows - ROW_W'(1);
    cmd.has_w    = out_col != '0;
    cmd.has_e    = out_col < cols - COL_W'(1);
    cmd.int_c    = rin_c && cin_c;
    cmd.int_n    = rin_n && cin_c;
    cmd.int_s    = rin_s && cin_c;
    cmd.int_w    = rin_c && cin_w;
    cmd.int_e    = rin_c && cin_e;
    cmd.last     = (out_row == rows - ROW_W'(1)) && (out_col == cols - COL_W'(1));
    cmd.in_slot  = in_slot;
    cmd.out_slot = out_slot;
    cmd.pix      = in_pix;
  end

  assign cmd_in_col  = in_col[CA_W-1:0];
  assign cmd_out_col = out_col[CA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= 2'd0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= 2'd0;
    end else if (push) begin
      if (in_col == cols - COL_W'(1)) begin
        in_col  <= '0;
        in_row  <= in_row + ROW_W'(1);
        in_slot <= slot_inc(in_slot);
      end else begin
        in_col <= in_col + COL_W'(1);
      end
      if (phase_out) begin
        if (cmd.last) begin
          // End of frame: the next item starts a fresh raster.
          in_row   <= '0;
          in_col   <= '0;
          in_slot  <= 2'd0;
          out_row  <= '0;
          out_col  <= '0;
          out_slot <= 2'd0;
        end else if (out_col == cols - COL_W'(1)) begin
          out_col  <= '0;
          out_row  <= out_row + ROW_W'(1);
          out_slot <= slot_inc(out_slot);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

endmodule

### hw/rtl/dews_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dews_queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dews_queue import dews_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QDEPTH,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output qstat_t           qstat
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign dout        = slots[rd_ptr];
  assign qstat.full  = count == CNT_W'(DEPTH);
  assign qstat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/dews_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dews_back
// Line stores, Sobel gradient, conductance divider and edge-weight output.
// ----------------------------------------------------------------------------
module dews_back import dews_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int CA_W  = $clog2(MAX_COLS),
  localparam int MA_W  = CA_W + 2,
  localparam int CNT_W = $clog2(COND_W + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  qstat_t            qstat,
  input  cmd_t              q_cmd,
  input  logic [CA_W-1:0]   q_in_col,
  input  logic [CA_W-1:0]   q_out_col,
  output logic              pop,
  input  logic [K_W-1:0]    k_sq,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WGT_W-1:0]  out_wn,
  output logic [WGT_W-1:0]  out_ws,
  output logic [WGT_W-1:0]  out_ww,
  output logic [WGT_W-1:0]  out_we,
  output logic [COND_W-1:0] out_cond,
  output logic              out_last
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PIX  = 4'd1;
  localparam logic [3:0] S_WIN  = 4'd2;
  localparam logic [3:0] S_GRAD = 4'd3;
  localparam logic [3:0] S_SQ   = 4'd4;
  localparam logic [3:0] S_DEN  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_CWR  = 4'd7;
  localparam logic [3:0] S_CRD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]       state;
  logic [CNT_W-1:0] cnt;
  cmd_t             cmd;
  logic [CA_W-1:0]  in_col, out_col;

  logic [PIX_W-1:0] pmem [2**MA_W];
  logic [COND_W-1:0] cmem [2**MA_W];
  logic [PIX_W-1:0] prd_a, prd_b;
  logic [COND_W-1:0] crd;
  logic [MA_W-1:0]  caddr;

  // Window rows: 0 is two rows up, 2 the current row. Columns: 2 is newest.
  logic [PIX_W-1:0] win [3][3];
  logic signed [GRAD_W-1:0] gx, gy;
  logic [SQ_W-1:0]  sqx, sqy;
  logic [DEN_W-1:0] den;
  logic [REM_W-1:0] rem;
  logic [COND_W-1:0] quo;
  logic [COND_W-1:0] cv [NREADS];

  logic [9:0] sum_r, sum_l, sum_b, sum_t;
  logic signed [GRAD_W-1:0] gx_c, gy_c;
  logic signed [2*GRAD_W-1:0] px, py;
  logic [K_W-1:0]   k_eff;
  logic             ge;
  logic [REM_W-1:0] rem_sub;
  logic [COND_W-1:0] cp, cn, cs, cw, ce;

  assign pop = (state == S_IDLE) && !qstat.empty;

  assign sum_r = {2'b0, win[0][2]} + {1'b0, win[1][2], 1'b0} + {2'b0, win[2][2]};
  assign sum_l = {2'b0, win[0][0]} + {1'b0, win[1][0], 1'b0} + {2'b0, win[2][0]};
  assign sum_b = {2'b0, win[2][0]} + {1'b0, win[2][1], 1'b0} + {2'b0, win[2][2]};
  assign sum_t = {2'b0, win[0][0]} + {1'b0, win[0][1], 1'b0} + {2'b0, win[0][2]};
  assign gx_c  = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
  assign gy_c  = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
  assign px    = gx * gx;
  assign py    = gy * gy;
  assign k_eff = (k_sq == '0) ? K_W'(1) : k_sq;

  assign ge      = rem >= REM_W'(den);
  assign rem_sub = ge ? rem - REM_W'(den) : rem;

  assign cp = cmd.int_c ? cv[1] : '0;
  assign cn = cmd.int_n ? cv[0] : '0;
  assign cs = cmd.int_s ? cv[2] : '0;
  assign cw = cmd.int_w ? cv[3] : '0;
  assign ce = cmd.int_e ? cv[4] : '0;

  always_comb begin
    case (cnt)
      CNT_W'(0): caddr = {slot_dec(cmd.out_slot), out_col};
      CNT_W'(2): caddr = {slot_inc(cmd.out_slot), out_col};
      CNT_W'(3): caddr = {cmd.out_slot, out_col - CA_W'(1)};
      CNT_W'(4): caddr = {cmd.out_slot, out_col + CA_W'(1)};
      default:   caddr = {cmd.out_slot, out_col};
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_PIX) begin
      pmem[{cmd.in_slot, in_col}] <= cmd.pix;
      prd_a <= pmem[{slot_inc(cmd.in_slot), in_col}];
      prd_b <= pmem[{slot_dec(cmd.in_slot), in_col}];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CWR) begin
      cmem[{slot_dec(cmd.in_slot), in_col - CA_W'(1)}] <= quo;
    end
    if (state == S_CRD) begin
      crd <= cmem[caddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!qstat.empty) begin
            cmd     <= q_cmd;
            in_col  <= q_in_col;
            out_col <= q_out_col;
            cnt     <= '0;
            state   <= q_cmd.wr ? S_PIX : S_CRD;
          end
        end
        S_PIX: state <= S_WIN;
        S_WIN: begin
          for (int i = 0; i < 3; i++) begin
            win[i][0] <= win[i][1];
            win[i][1] <= win[i][2];
          end
          win[0][2] <= prd_a;
          win[1][2] <= prd_b;
          win[2][2] <= cmd.pix;
          cnt       <= '0;
          state     <= cmd.cond_do ? S_GRAD : (cmd.outp ? S_CRD : S_IDLE);
        end
        S_GRAD: begin
          gx    <= gx_c;
          gy    <= gy_c;
          state <= S_SQ;
        end
        S_SQ: begin
          sqx   <= SQ_W'($unsigned(px));
          sqy   <= SQ_W'($unsigned(py));
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= DEN_W'(k_eff) + DEN_W'(sqx) + DEN_W'(sqy);
          rem   <= REM_W'(k_eff);
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // One quotient bit a cycle; the first step decides the integer bit.
          rem <= {rem_sub[REM_W-2:0], 1'b0};
          quo <= {quo[COND_W-2:0], ge};
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(COND_W - 1)) begin
            state <= S_CWR;
          end
        end
        S_CWR: begin
          cnt   <= '0;
          state <= cmd.outp ? S_CRD : S_IDLE;
        end
        S_CRD: begin
          // Read address goes out in one cycle, data is caught in the next.
          if (cnt != '0) begin
            cv[3'(cnt - CNT_W'(1))] <= crd;
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NREADS)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_wn    <= cmd.has_n ? WGT_W'(cp) + WGT_W'(cn) : '0;
            out_ws    <= cmd.has_s ? WGT_W'(cp) + WGT_W'(cs) : '0;
            out_ww    <= cmd.has_w ? WGT_W'(cp) + WGT_W'(cw) : '0;
            out_we    <= cmd.has_e ? WGT_W'(cp) + WGT_W'(ce) : '0;
            out_cond  <= cp;
            out_last  <= cmd.last;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### verif/diffusion_edge_weight_stencil_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffusion_edge_weight_stencil_checker
// Watches the pixel, result and register channels of the stencil. Keeps its
// own copy of the line stores and frame counters, works out the north, south,
// west and east edge weights and the conductance when an accepted pixel or
// flush has a result due, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module diffusion_edge_weight_stencil_checker import dews_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [0:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    mismatches,
  output int                    pending
);

  typedef struct {
    logic [WGT_W-1:0]  north;
    logic [WGT_W-1:0]  south;
    logic [WGT_W-1:0]  west;
    logic [WGT_W-1:0]  east;
    logic [COND_W-1:0] cond;
    logic              last;
  } edge_weights_t;

  edge_weights_t expected_weights[$];

  logic [ROWS_REG_W-1:0] rows_reg;
  logic [COLS_REG_W-1:0] cols_reg;
  logic [K_W-1:0]        ksq_reg;
  logic [PIX_W-1:0]      pix_rows[3][DEF_MAX_COLS];
  logic [COND_W-1:0]     cond_rows[3][DEF_MAX_COLS];
  longint                in_row, in_col, out_row, out_col;

  function automatic longint eff_rows();
    longint r;
    r = rows_reg;
    if (r < 3) r = 3;
    if (r > DEF_MAX_ROWS) r = DEF_MAX_ROWS;
    return r;
  endfunction

  function automatic longint eff_cols();
    longint c;
    c = cols_reg;
    if (c < 3) c = 3;
    if (c > DEF_MAX_COLS) c = DEF_MAX_COLS;
    return c;
  endfunction

  function automatic longint pix(longint r, longint c);
    return longint'(pix_rows[r % 3][c % DEF_MAX_COLS]);
  endfunction

  function automatic longint cond_at(longint r, longint c, longint rows, longint cols);
    if (r < 1 || r > rows - 2 || c < 1 || c > cols - 2) return 0;
    return longint'(cond_rows[r % 3][c % DEF_MAX_COLS]);
  endfunction

  task automatic restart_frame();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endtask

  // Sobel gradient over rows r-1..r+1, then floor(k * 2^FRAC_BITS / (k + g^2)).
  task automatic update_conductance(longint r, longint c);
    longint gx, gy, g2, k;
    gx = (pix(r-1, c+1) + 2 * pix(r, c+1) + pix(r+1, c+1))
       - (pix(r-1, c-1) + 2 * pix(r, c-1) + pix(r+1, c-1));
    gy = (pix(r+1, c-1) + 2 * pix(r+1, c) + pix(r+1, c+1))
       - (pix(r-1, c-1) + 2 * pix(r-1, c) + pix(r-1, c+1));
    g2 = gx * gx + gy * gy;
    k = (ksq_reg == 0) ? 1 : longint'(ksq_reg);
    cond_rows[r % 3][c % DEF_MAX_COLS] = COND_W'((k << FRAC_BITS) / (k + g2));
  endtask

  task automatic take_item(logic op, logic [PIX_W-1:0] px);
    longint rows, cols, total, lag, lin, cp;
    edge_weights_t w;
    rows = eff_rows();
    cols = eff_cols();
    total = rows * cols;
    lag = 2 * cols + 1;
    if (in_row > rows + 2 || in_col >= cols || out_row >= rows || out_col >= cols)
      restart_frame();
    lin = in_row * cols + in_col;
    if (lin >= total + lag) begin
      restart_frame();
      lin = 0;
    end
    if (lin < total) begin
      // A flush that arrives before the frame is complete changes nothing.
      if (op == OP_FLUSH) return;
      pix_rows[in_row % 3][in_col] = px;
      if (in_row >= 2 && in_col >= 2) update_conductance(in_row - 1, in_col - 1);
    end
    in_col++;
    if (in_col >= cols) begin
      in_col = 0;
      in_row++;
    end
    if (lin < lag) return;
    cp = cond_at(out_row, out_col, rows, cols);
    w.cond  = COND_W'(cp);
    w.north = (out_row > 0) ? WGT_W'(cp + cond_at(out_row-1, out_col, rows, cols)) : '0;
    w.south = (out_row + 1 < rows) ?
              WGT_W'(cp + cond_at(out_row+1, out_col, rows, cols)) : '0;
    w.west  = (out_col > 0) ? WGT_W'(cp + cond_at(out_row, out_col-1, rows, cols)) : '0;
    w.east  = (out_col + 1 < cols) ?
              WGT_W'(cp + cond_at(out_row, out_col+1, rows, cols)) : '0;
    w.last  = (out_row + 1 == rows) && (out_col + 1 == cols);
    expected_weights.push_back(w);
    if (w.last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= cols) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  task automatic check_result();
    edge_weights_t w, got;
    got.north = m_tdata[WGT_W-1:0];
    got.south = m_tdata[2*WGT_W-1:WGT_W];
    got.west  = m_tdata[3*WGT_W-1:2*WGT_W];
    got.east  = m_tdata[4*WGT_W-1:3*WGT_W];
    got.cond  = m_tdata[4*WGT_W+COND_W-1:4*WGT_W];
    got.last  = m_tlast;
    if (expected_weights.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result transfer n=%0d s=%0d w=%0d e=%0d c=%0d last=%0b",
                 $realtime, got.north, got.south, got.west, got.east, got.cond, got.last);
      return;
    end
    w = expected_weights.pop_front();
    if (got.north !== w.north || got.south !== w.south || got.west !== w.west ||
        got.east !== w.east || got.cond !== w.cond || got.last !== w.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch", $realtime);
        $display("  expected n=%0d s=%0d w=%0d e=%0d c=%0d last=%0b",
                 w.north, w.south, w.west, w.east, w.cond, w.last);
        $display("  actual   n=%0d s=%0d w=%0d e=%0d c=%0d last=%0b",
                 got.north, got.south, got.west, got.east, got.cond, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      ksq_reg = K_RESET;
      mismatches = 0;
      restart_frame();
      expected_weights.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS: begin
            rows_reg = cfg_data[ROWS_REG_W-1:0];
            restart_frame();
          end
          REG_COLS: begin
            cols_reg = cfg_data[COLS_REG_W-1:0];
            restart_frame();
          end
          REG_KSQ: ksq_reg = cfg_data[K_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) take_item(s_tuser[0], s_tdata[PIX_W-1:0]);
      if (m_tvalid && m_tready) check_result();
    end
    pending = expected_weights.size();
  end

endmodule

### verif/diffusion_edge_weight_stencil_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diffusion_edge_weight_stencil_tb
// Streams small grey frames through the stencil under a range of geometry
// and K settings, with random gaps on both channels, one long output stall,
// aborted frames, stray flushes and late pixels. A checker module predicts
// and compares every result.
// ----------------------------------------------------------------------------
module diffusion_edge_weight_stencil_tb;
  import dews_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // pixel
  logic [0:0]            s_tuser;   // op
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // wn, ws, ww, we, conductance, zero fill
  logic                  m_tlast;   // frame_last
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  int   mismatches;
  int   pending;
  int   items_sent;
  bit   idle_en;
  bit   hold_req;
  bit   held;

  always #4 clk = ~clk;

  diffusion_edge_weight_stencil i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_we, .cfg_index, .cfg_data
  );

  diffusion_edge_weight_stencil_checker i_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .pending
  );

  // Result side: random stalls, and one long hold-off so the input queue fills.
  // The hold-off outlasts the quiet period before the frame, so it overlaps
  // plenty of input traffic.
  initial begin
    m_tready <= 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (1000) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send(logic op, logic [PIX_W-1:0] px);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Registers may only change once every prediction is met and the back end
  // has had time to drain items that produce no result.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    cfg_we <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
  endtask

  // style: 0 random grey, 1 black/white only, 2 flat
  function automatic logic [PIX_W-1:0] next_pixel(int style);
    case (style)
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: return 8'h80;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // abort_at < 0 runs the whole frame and its flush tail.
  task automatic run_frame(int rows_val, int cols_val, int ksq_val, int style, int abort_at);
    int rows, cols, i;
    rows = (rows_val < 3) ? 3 : (rows_val > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows_val);
    cols = (cols_val < 3) ? 3 : (cols_val > DEF_MAX_COLS ? DEF_MAX_COLS : cols_val);
    wait_quiet();
    write_reg(REG_ROWS, CFG_W'(rows_val));
    write_reg(REG_COLS, CFG_W'(cols_val));
    write_reg(REG_KSQ, CFG_W'(ksq_val));
    cfg_we <= 1'b0;
    for (i = 0; i < rows * cols; i++) begin
      if (abort_at >= 0 && i == abort_at) return;
      // Early flushes are ignored by the block.
      if ($urandom_range(0, 15) == 0) send(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
      send(OP_PIXEL, next_pixel(style));
    end
    // Late pixels count as flushes, so the tail mixes both kinds.
    for (i = 0; i < 2 * cols + 1; i++)
      send(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) send(OP_FLUSH, PIX_W'($urandom_range(0, 255)));
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    items_sent = 0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: clamped geometry, zero and full-scale K, hard edges, oversized frames.
    run_frame(0, 0, 0, 1, -1);
    run_frame(3, 3, 65535, 1, -1);
    run_frame(2047, 3, 1, 0, 30);
    run_frame(3, 4095, 65535, 1, 12);
    run_frame(4, 3, 100, 2, -1);

    // Long result stall while pixels keep coming.
    hold_req = 1'b1;
    run_frame(5, 6, 400, 0, -1);

    while (items_sent < 1450) begin
      if (items_sent > 1200) idle_en = 1'b0;
      run_frame($urandom_range(2, 7), $urandom_range(2, 10),
                $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(1, 2000),
                $urandom_range(0, 1), $urandom_range(0, 9) == 0 ? $urandom_range(0, 20) : -1);
    end
    wait_quiet();
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
